FILE: design/kce_pkg.sv
// Shared constants and types for the k-combination enumerator.
`timescale 1ns / 1ps

package kce_pkg;

   // Field widths fixed by the register map and the result format.
   localparam int SET_SIZE_W      = 7;
   localparam int PICK_COUNT_W    = 5;
   localparam int ELEMENT_INDEX_W = 7;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [SET_SIZE_W-1:0]   SET_SIZE_RESET   = 7'd6;
   localparam logic [PICK_COUNT_W-1:0] PICK_COUNT_RESET = 5'd4;

   // Default sizing of the position store and the element range.
   localparam int MAX_PICK_DEFAULT = 16;
   localparam int MAX_SET_DEFAULT  = 64;

   // Register index, taken from the word address.
   typedef enum logic {
      REG_SET_SIZE   = 1'b0,
      REG_PICK_COUNT = 1'b1
   } reg_index_type;

endpackage

FILE: design/kce_req_if.sv
// Request channel: valid/ready handshake carrying the restart flag.
`timescale 1ns / 1ps

interface kce_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

FILE: design/kce_rsp_if.sv
// Result channel: valid/ready handshake carrying one element of a combination.
`timescale 1ns / 1ps

interface kce_rsp_if;
   import kce_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ELEMENT_INDEX_W-1:0] element_index;
   logic                       run_last;
   logic                       final_combination;
   logic                       exhausted;

   modport source (output valid, output element_index, output run_last,
                   output final_combination, output exhausted, input ready);
   modport sink   (input valid, input element_index, input run_last,
                   input final_combination, input exhausted, output ready);
endinterface

FILE: design/k_combination_enumerator_unit.sv
// Top level of the lexicographic k-combination enumerator.
`timescale 1ns / 1ps

// Each accepted request returns the current k-subset of {1..n} as k result
// transfers in increasing order, the last one marked with run_last, and then
// steps to the next subset in lexicographic order. The positions live in a
// small register store with one read and one write port, and a sequencer walks
// a single index over it: it loads 1..k (first request, restart or after a
// register write), scans from the right for the pivot, emits the subset, and
// then increments the pivot and refills the later positions. Any stall on the
// result side holds the emit and exhaustion steps; a request that can only
// report exhaustion returns one exhausted transfer. The request side is ready
// only while the sequencer is idle. Registers set_size (byte address 0) and
// pick_count (byte address 4) read back as written but are used saturated at
// MAX_SET and MAX_PICK, and writing either restarts the enumeration.
module k_combination_enumerator_unit #(
   parameter int MAX_PICK = kce_pkg::MAX_PICK_DEFAULT,
   parameter int MAX_SET  = kce_pkg::MAX_SET_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   kce_req_if.sink                               req_in,
   kce_rsp_if.source                             rsp_out,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [kce_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [kce_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [kce_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import kce_pkg::*;

   localparam int IW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
   localparam int PW = $clog2(MAX_SET + 1);
   localparam int KW = $clog2(MAX_PICK + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_EMIT = 6'b001000,
      ST_ADV  = 6'b010000,
      ST_EXH  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic [IW-1:0]               pivot_ff, pivot_in;
   logic                        last_ff, last_in;
   logic [PW-1:0]               run_ff, run_in;
   logic                        fresh_ff, fresh_in;
   logic                        finished_ff, finished_in;
   logic [SET_SIZE_W-1:0]       set_size_ff, set_size_in;
   logic [PICK_COUNT_W-1:0]     pick_count_ff, pick_count_in;

   logic                        out_valid_ff, out_valid_in;
   logic [ELEMENT_INDEX_W-1:0]  out_index_ff, out_index_in;
   logic                        out_run_last_ff, out_run_last_in;
   logic                        out_final_ff, out_final_in;
   logic                        out_exhausted_ff, out_exhausted_in;

   logic [PW-1:0]               positions [MAX_PICK];
   logic                        mem_we;
   logic [PW-1:0]               mem_wd;
   logic [PW-1:0]               rd;

   logic [PW-1:0]               n_val;
   logic [KW-1:0]               k_val;
   logic                        bad_pick;
   logic [IW-1:0]               k_last;
   logic [PW-1:0]               limit;
   logic                        slot_free;
   logic                        load_out;
   logic                        cfg_we;
   reg_index_type               cfg_reg;

   // Saturated view of the registers.
   assign n_val = (32'(set_size_ff) > 32'(MAX_SET)) ? PW'(MAX_SET) : PW'(set_size_ff);
   assign k_val = (32'(pick_count_ff) > 32'(MAX_PICK)) ? KW'(MAX_PICK) : KW'(pick_count_ff);
   assign bad_pick = (k_val == '0) || (32'(k_val) > 32'(n_val));
   assign k_last   = IW'(32'(k_val) - 32'd1);

   // Limit of the position under the cursor: n - k + (idx + 1).
   assign limit = PW'(32'(n_val) - 32'(k_val) + 32'(idx_ff) + 32'd1);

   assign rd        = positions[idx_ff];
   assign slot_free = !out_valid_ff || rsp_out.ready;

   assign cfg_we  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_reg = reg_index_type'(csr_paddr[2]);

   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_reg)
         REG_SET_SIZE:   csr_prdata = CSR_DATA_W'(set_size_ff);
         REG_PICK_COUNT: csr_prdata = CSR_DATA_W'(pick_count_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      pivot_in         = pivot_ff;
      last_in          = last_ff;
      run_in           = run_ff;
      fresh_in         = fresh_ff;
      finished_in      = finished_ff;
      set_size_in      = set_size_ff;
      pick_count_in    = pick_count_ff;
      mem_we           = 1'b0;
      mem_wd           = '0;
      load_out         = 1'b0;
      out_index_in     = out_index_ff;
      out_run_last_in  = out_run_last_ff;
      out_final_in     = out_final_ff;
      out_exhausted_in = out_exhausted_ff;
      req_in.ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_in.ready = 1'b1;
            if (req_in.valid) begin
               if (bad_pick) begin
                  state_in = ST_EXH;
               end else if (req_in.restart || fresh_ff) begin
                  state_in    = ST_LOAD;
                  idx_in      = '0;
                  fresh_in    = 1'b0;
                  finished_in = 1'b0;
               end else if (finished_ff) begin
                  state_in = ST_EXH;
               end else begin
                  state_in = ST_SCAN;
                  idx_in   = k_last;
               end
            end
         end
         ST_LOAD: begin
            mem_we = 1'b1;
            mem_wd = PW'(32'(idx_ff) + 32'd1);
            if (idx_ff == k_last) begin
               state_in = ST_SCAN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_SCAN: begin
            // Walk from the right until a position sits below its limit.
            if (rd != limit) begin
               pivot_in = idx_ff;
               last_in  = 1'b0;
               state_in = ST_EMIT;
               idx_in   = '0;
            end else if (idx_ff == '0) begin
               last_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff - IW'(1);
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load_out         = 1'b1;
               out_index_in     = ELEMENT_INDEX_W'(rd);
               out_run_last_in  = (idx_ff == k_last);
               out_final_in     = last_ff;
               out_exhausted_in = 1'b0;
               if (idx_ff == k_last) begin
                  if (last_ff) begin
                     finished_in = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     state_in = ST_ADV;
                     idx_in   = pivot_ff;
                  end
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ST_ADV: begin
            // The pivot is incremented, every later position follows on by one.
            mem_we = 1'b1;
            mem_wd = (idx_ff == pivot_ff) ? rd + PW'(1) : run_ff + PW'(1);
            run_in = mem_wd;
            if (idx_ff == k_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_EXH: begin
            if (slot_free) begin
               load_out         = 1'b1;
               out_index_in     = '0;
               out_run_last_in  = 1'b1;
               out_final_in     = 1'b0;
               out_exhausted_in = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_we) begin
         unique case (cfg_reg)
            REG_SET_SIZE:   set_size_in   = csr_pwdata[SET_SIZE_W-1:0];
            REG_PICK_COUNT: pick_count_in = csr_pwdata[PICK_COUNT_W-1:0];
            default:        set_size_in   = set_size_ff;
         endcase
         fresh_in    = 1'b1;
         finished_in = 1'b0;
      end

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_out.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pivot_ff      <= '0;
         last_ff       <= 1'b0;
         fresh_ff      <= 1'b1;
         finished_ff   <= 1'b0;
         set_size_ff   <= SET_SIZE_RESET;
         pick_count_ff <= PICK_COUNT_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pivot_ff      <= pivot_in;
         last_ff       <= last_in;
         fresh_ff      <= fresh_in;
         finished_ff   <= finished_in;
         set_size_ff   <= set_size_in;
         pick_count_ff <= pick_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff           <= run_in;
      out_index_ff     <= out_index_in;
      out_run_last_ff  <= out_run_last_in;
      out_final_ff     <= out_final_in;
      out_exhausted_ff <= out_exhausted_in;
      if (mem_we) begin
         positions[idx_ff] <= mem_wd;
      end
   end

   assign rsp_out.valid             = out_valid_ff;
   assign rsp_out.element_index     = out_index_ff;
   assign rsp_out.run_last          = out_run_last_ff;
   assign rsp_out.final_combination = out_final_ff;
   assign rsp_out.exhausted         = out_exhausted_ff;

endmodule

FILE: bench/kce_combination_check.sv
// Watches the enumerator's channels, predicts every result transfer and compares it.
`timescale 1ns / 1ps

module kce_combination_check (
   input  logic                           clock,
   input  logic                           reset,
   kce_req_if                             req_mon,
   kce_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [kce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             failures,
   output int                             outstanding,
   output int                             runs_predicted,
   output int                             final_runs,
   output int                             exhausted_results
);
   import kce_pkg::*;

   typedef struct packed {
      logic [ELEMENT_INDEX_W-1:0] element_index;
      logic                       run_last;
      logic                       final_combination;
      logic                       exhausted;
   } element_type;

   logic [SET_SIZE_W-1:0]      set_size_q;
   logic [PICK_COUNT_W-1:0]    pick_count_q;
   logic [ELEMENT_INDEX_W-1:0] positions [MAX_PICK_DEFAULT];
   bit                         fresh;
   bit                         finished;
   element_type                expected_elements [$];

   task automatic push_exhausted();
      element_type e;
      e.element_index     = '0;
      e.run_last          = 1'b1;
      e.final_combination = 1'b0;
      e.exhausted         = 1'b1;
      expected_elements.push_back(e);
      exhausted_results++;
   endtask

   // Emits the current subset and steps to its lexicographic successor, or emits an exhausted result.
   task automatic advance_combination(input logic restart);
      int          n;
      int          k;
      int          i;
      int          j;
      int          pivot;
      element_type e;
      n = (set_size_q > MAX_SET_DEFAULT) ? MAX_SET_DEFAULT : int'(set_size_q);
      k = (pick_count_q > MAX_PICK_DEFAULT) ? MAX_PICK_DEFAULT : int'(pick_count_q);
      if (k == 0 || k > n) begin
         push_exhausted();
         return;
      end
      if (restart || fresh) begin
         for (i = 0; i < k; i++) positions[i] = ELEMENT_INDEX_W'(i + 1);
         fresh    = 1'b0;
         finished = 1'b0;
      end
      if (finished) begin
         push_exhausted();
         return;
      end
      pivot = 0;
      for (j = k; j > 0 && pivot == 0; j--) begin
         if (int'(positions[j-1]) != n - k + j) pivot = j;
      end
      for (i = 0; i < k; i++) begin
         e.element_index     = positions[i];
         e.run_last          = (i == k - 1);
         e.final_combination = (pivot == 0);
         e.exhausted         = 1'b0;
         expected_elements.push_back(e);
      end
      runs_predicted++;
      if (pivot == 0) begin
         finished = 1'b1;
         final_runs++;
      end else begin
         positions[pivot-1] = positions[pivot-1] + 1'b1;
         for (j = pivot; j < k; j++) positions[j] = positions[j-1] + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      element_type got;
      element_type want;
      if (reset) begin
         set_size_q        = SET_SIZE_RESET;
         pick_count_q      = PICK_COUNT_RESET;
         fresh             = 1'b1;
         finished          = 1'b0;
         failures          = 0;
         runs_predicted    = 0;
         final_runs        = 0;
         exhausted_results = 0;
         expected_elements.delete();
      end else begin
         // A request is predicted before results are checked, so that a result
         // leaving on the same edge still finds its expectation.
         if (req_mon.valid && req_mon.ready) advance_combination(req_mon.restart);

         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_SET_SIZE:   set_size_q   = csr_pwdata[SET_SIZE_W-1:0];
               REG_PICK_COUNT: pick_count_q = csr_pwdata[PICK_COUNT_W-1:0];
            endcase
            fresh    = 1'b1;
            finished = 1'b0;
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.element_index     = rsp_mon.element_index;
            got.run_last          = rsp_mon.run_last;
            got.final_combination = rsp_mon.final_combination;
            got.exhausted         = rsp_mon.exhausted;
            if (expected_elements.size() == 0) begin
               failures++;
               if (failures <= 40)
                  $display("%0t: unexpected result transfer: index %0d last %0b final %0b exh %0b",
                           $time, got.element_index, got.run_last, got.final_combination,
                           got.exhausted);
            end else begin
               want = expected_elements.pop_front();
               if (got.element_index !== want.element_index || got.run_last !== want.run_last ||
                   got.final_combination !== want.final_combination ||
                   got.exhausted !== want.exhausted) begin
                  failures++;
                  // The report is capped so that a badly broken block cannot flood the log.
                  if (failures <= 40)
                     $display({"%0t: mismatch: expected index %0d last %0b final %0b exh %0b,",
                               " got index %0d last %0b final %0b exh %0b"},
                              $time, want.element_index, want.run_last,
                              want.final_combination, want.exhausted, got.element_index,
                              got.run_last, got.final_combination, got.exhausted);
               end
            end
         end
      end
      outstanding = expected_elements.size();
   end

endmodule

FILE: bench/tb.sv
// Top of the enumerator testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
   import kce_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int runs_predicted;
   int final_runs;
   int exhausted_results;
   int requests_sent;
   int send_idle_pct;
   int stall_pct;

   kce_req_if req_if ();
   kce_rsp_if rsp_if ();

   k_combination_enumerator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_in      (req_if),
      .rsp_out     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kce_combination_check u_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .failures          (failures),
      .outstanding       (outstanding),
      .runs_predicted    (runs_predicted),
      .final_runs        (final_runs),
      .exhausted_results (exhausted_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_if.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #4_000_000;
      $display("tb: run did not complete in time");
      $display("tb: failure");
      $finish;
   end

   // Idling profile: no gaps, a sparse sender, a stalling receiver, or light gaps on both.
   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 67; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 67; end
         default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
   endtask

   // Setup and access phases; the upper data bits carry noise the register must ignore.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] noise;
      logic        done;
      noise = $urandom();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      if (idx == REG_SET_SIZE)
         csr_pwdata <= {noise[31:SET_SIZE_W], value[SET_SIZE_W-1:0]};
      else
         csr_pwdata <= {noise[31:PICK_COUNT_W], value[PICK_COUNT_W-1:0]};
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_pready;
         @(posedge clock);
      end while (!done);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_request(input logic restart);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid   <= 1'b0;
         req_if.restart <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      do begin
         @(negedge clock);
         taken = req_if.ready;
         @(posedge clock);
      end while (!taken);
      requests_sent++;
   endtask

   // Waits for every expected transfer, then lets the block finish its refill.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4 * MAX_PICK_DEFAULT + 8) @(posedge clock);
   endtask

   initial begin
      int phase;
      int r;
      int n;
      int k;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      rsp_if.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      requests_sent  = 0;
      set_idling(0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, six choose four: all fifteen subsets, one past the end, then a restart.
      repeat (16) send_request(1'b0);
      send_request(1'b1);
      drain();
      write_register(REG_PICK_COUNT, 0);
      send_request(1'b0);
      drain();
      // Both registers above their ceilings saturate to 64 and 16.
      write_register(REG_SET_SIZE, 127);
      write_register(REG_PICK_COUNT, 31);
      send_request(1'b0);
      drain();
      // Sixteen of sixteen has a single subset, which is also the last.
      write_register(REG_SET_SIZE, 16);
      send_request(1'b0);
      send_request(1'b0);
      drain();
      write_register(REG_SET_SIZE, 0);
      write_register(REG_PICK_COUNT, 1);
      send_request(1'b0);
      drain();
      write_register(REG_SET_SIZE, 3);
      write_register(REG_PICK_COUNT, 5);
      send_request(1'b0);
      drain();
      write_register(REG_SET_SIZE, 1);
      write_register(REG_PICK_COUNT, 1);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      drain();

      for (phase = 0; phase < 10; phase++) begin
         set_idling(phase);
         r = $urandom_range(9);
         if (r < 7) begin
            n = $urandom_range(1, 9);
            k = $urandom_range(1, n);
         end else if (r == 7) begin
            n = $urandom_range(0, 127);
            k = $urandom_range(0, 31);
         end else begin
            n = $urandom_range(60, 64);
            k = $urandom_range(1, 16);
         end
         // Half the time both registers change; otherwise only one, which still restarts the walk.
         r = $urandom_range(3);
         if (r != 1) write_register(REG_SET_SIZE, n);
         if (r != 2) write_register(REG_PICK_COUNT, k);
         repeat (22) send_request($urandom_range(99) < 6);
         drain();
      end

      $display("tb: %0d requests sent, %0d combinations checked, %0d of them final,",
               requests_sent, runs_predicted, final_runs);
      $display("tb: %0d exhausted results, under four idling profiles", exhausted_results);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
